FILE: src/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// mcfe_pkg: shared definitions for the motor command frame encoder
// Frame kinds, identifier types, register indexes and the job word.
// ----------------------------------------------------------------------------
package mcfe_pkg;

  localparam int CODE_BITS_DEF = 16;
  localparam int LIM_W         = 31;
  localparam int HOST_W        = 8;
  localparam int VAL_W         = 33;
  localparam int NUM_LANES     = 5;

  localparam logic [LIM_W-1:0]  POS_LIM_RST  = 31'd823550;
  localparam logic [LIM_W-1:0]  VEL_LIM_RST  = 31'd983040;
  localparam logic [LIM_W-1:0]  TRQ_LIM_RST  = 31'd7864320;
  localparam logic [LIM_W-1:0]  KP_LIM_RST   = 31'd327680000;
  localparam logic [LIM_W-1:0]  KD_LIM_RST   = 31'd6553600;
  localparam logic [HOST_W-1:0] HOST_RST     = 8'd0;

  localparam logic [2:0] FUNC_MOTION = 3'd0;
  localparam logic [2:0] FUNC_ENABLE = 3'd1;
  localparam logic [2:0] FUNC_STOP   = 3'd2;
  localparam logic [2:0] FUNC_ZERO   = 3'd3;
  localparam logic [2:0] FUNC_PARAM  = 3'd4;

  localparam logic [4:0] TYPE_MOTION = 5'h01;
  localparam logic [4:0] TYPE_ENABLE = 5'h03;
  localparam logic [4:0] TYPE_STOP   = 5'h04;
  localparam logic [4:0] TYPE_ZERO   = 5'h06;
  localparam logic [4:0] TYPE_PARAM  = 5'h12;

  localparam logic [2:0] CFG_POS_LIM = 3'd0;
  localparam logic [2:0] CFG_VEL_LIM = 3'd1;
  localparam logic [2:0] CFG_TRQ_LIM = 3'd2;
  localparam logic [2:0] CFG_KP_LIM  = 3'd3;
  localparam logic [2:0] CFG_KD_LIM  = 3'd4;
  localparam logic [2:0] CFG_HOST    = 3'd5;

  localparam logic [63:0] DATA_BYTE0_ONE = 64'h0100_0000_0000_0000;

  typedef struct packed {
    logic [VAL_W-1:0] off;
    logic [VAL_W-1:0] span;
  } lane_op_t;

  typedef struct packed {
    logic        is_motion;
    logic [28:0] frame_id;
    logic [63:0] frame_data;
    lane_op_t    trq;
    lane_op_t    pos;
    lane_op_t    vel;
    lane_op_t    kp;
    lane_op_t    kd;
  } job_t;

  function automatic lane_op_t sym_op(logic signed [31:0] x, logic [LIM_W-1:0] lim);
    logic signed [33:0] xs;
    logic signed [33:0] ls;
    logic signed [33:0] sum;
    lane_op_t           op;
    xs = 34'(x);
    ls = $signed({3'b000, lim});
    sum = xs + ls;
    op.span = {1'b0, lim, 1'b0};
    if (sum < 0) begin
      op.off = '0;
    end else if (xs > ls) begin
      op.off = {1'b0, lim, 1'b0};
    end else begin
      op.off = sum[VAL_W-1:0];
    end
    return op;
  endfunction

  function automatic lane_op_t gain_op(logic [31:0] x, logic [LIM_W-1:0] lim);
    lane_op_t op;
    op.span = {2'b00, lim};
    if (x[31]) begin
      op.off = '0;
    end else if (x[30:0] > lim) begin
      op.off = {2'b00, lim};
    end else begin
      op.off = {2'b00, x[30:0]};
    end
    return op;
  endfunction

endpackage

FILE: src/mcfe_quant.sv
// ----------------------------------------------------------------------------
// mcfe_quant: one operand lane with a radix-2 restoring divider
// Computes floor((2*off*(2^N-1) + span) / (2*span)), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mcfe_quant
  import mcfe_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  lane_op_t             op,
  output logic                 done,
  output logic [CODE_BITS-1:0] code
);

  localparam int NUM_W = CODE_BITS + VAL_W;
  localparam int N_W   = CODE_BITS + VAL_W + 1;
  localparam int REM_W = VAL_W + 1;
  localparam int CNT_W = $clog2(CODE_BITS + 1);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_PREP = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_t;

  lane_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     num_r;
  logic [VAL_W-1:0]     span_r;
  logic                 zero_r;
  logic [REM_W-1:0]     rem_r;
  logic [CODE_BITS-1:0] q_r;
  logic [N_W-1:0]       dividend;
  logic [REM_W:0]       ext;
  logic [REM_W:0]       dvs;
  logic [REM_W:0]       diff;
  logic                 ge;

  assign dividend = {num_r, 1'b0} + N_W'(span_r);
  assign ext      = {rem_r, q_r[CODE_BITS-1]};
  assign dvs      = {1'b0, span_r, 1'b0};
  assign ge       = (ext >= dvs);
  assign diff     = ext - dvs;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      L_IDLE, L_DONE: begin
        if (start) begin
          state_nxt = L_PREP;
        end
      end
      L_PREP: begin
        state_nxt = L_DIV;
        cnt_nxt   = CNT_W'(CODE_BITS);
      end
      L_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = L_DONE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == L_IDLE || state_r == L_DONE) && start) begin
      num_r  <= {op.off, {CODE_BITS{1'b0}}} - NUM_W'(op.off);
      span_r <= op.span;
      zero_r <= (op.span == '0);
    end
    if (state_r == L_PREP) begin
      rem_r <= dividend[N_W-1:CODE_BITS];
      q_r   <= dividend[CODE_BITS-1:0];
    end else if (state_r == L_DIV) begin
      rem_r <= ge ? diff[REM_W-1:0] : ext[REM_W-1:0];
      q_r   <= {q_r[CODE_BITS-2:0], ge};
    end
  end

  assign done = (state_r == L_DONE);
  assign code = zero_r ? '0 : q_r;

endmodule

FILE: src/mcfe_front.sv
// ----------------------------------------------------------------------------
// mcfe_front: request intake and classification
// Clamps motion operands into lane jobs and builds all other frames whole.
// ----------------------------------------------------------------------------
module mcfe_front
  import mcfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_func,
  input  logic [7:0]        in_node_id,
  input  logic signed [31:0] in_torque,
  input  logic signed [31:0] in_position,
  input  logic signed [31:0] in_velocity,
  input  logic signed [31:0] in_stiffness_gain,
  input  logic signed [31:0] in_damping_gain,
  input  logic              in_fault_ack,
  input  logic [15:0]       in_parameter_index,
  input  logic [31:0]       in_parameter_bits,
  input  logic [LIM_W-1:0]  pos_lim,
  input  logic [LIM_W-1:0]  vel_lim,
  input  logic [LIM_W-1:0]  trq_lim,
  input  logic [LIM_W-1:0]  kp_lim,
  input  logic [LIM_W-1:0]  kd_lim,
  input  logic [HOST_W-1:0] host,
  output logic              job_valid,
  input  logic              job_full,
  output job_t              job
);

  logic valid_r, valid_nxt;
  logic accept;
  job_t job_r, job_nxt;

  assign in_stall = valid_r && job_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    job_nxt            = '0;
    job_nxt.trq        = sym_op(in_torque, trq_lim);
    job_nxt.pos        = sym_op(in_position, pos_lim);
    job_nxt.vel        = sym_op(in_velocity, vel_lim);
    job_nxt.kp         = gain_op(in_stiffness_gain, kp_lim);
    job_nxt.kd         = gain_op(in_damping_gain, kd_lim);
    case (in_func)
      FUNC_MOTION: begin
        job_nxt.is_motion = 1'b1;
        job_nxt.frame_id  = {TYPE_MOTION, 16'h0000, in_node_id};
      end
      FUNC_ENABLE: begin
        job_nxt.frame_id = {TYPE_ENABLE, 8'h00, host, in_node_id};
      end
      FUNC_STOP: begin
        job_nxt.frame_id = {TYPE_STOP, 8'h00, host, in_node_id};
        if (in_fault_ack) begin
          job_nxt.frame_data = DATA_BYTE0_ONE;
        end
      end
      FUNC_ZERO: begin
        job_nxt.frame_id   = {TYPE_ZERO, 8'h00, host, in_node_id};
        job_nxt.frame_data = DATA_BYTE0_ONE;
      end
      FUNC_PARAM: begin
        job_nxt.frame_id   = {TYPE_PARAM, 8'h00, host, in_node_id};
        job_nxt.frame_data = {in_parameter_index[7:0], in_parameter_index[15:8], 16'h0000,
                              in_parameter_bits[7:0], in_parameter_bits[15:8],
                              in_parameter_bits[23:16], in_parameter_bits[31:24]};
      end
      default: begin
        job_nxt.frame_id = '0;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (!job_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = valid_r;
  assign job       = job_r;

endmodule

FILE: src/mcfe_queue.sv
// ----------------------------------------------------------------------------
// mcfe_queue: two-entry job queue between front and back
// Lets the intake keep taking requests while the lanes are busy.
// ----------------------------------------------------------------------------
module mcfe_queue
  import mcfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic full,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: src/mcfe_back.sv
// ----------------------------------------------------------------------------
// mcfe_back: frame execution and output register
// Runs the five quantizer lanes for motion frames and drives the result word.
// ----------------------------------------------------------------------------
module mcfe_back
  import mcfe_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_pop,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [28:0] out_frame_id,
  output logic [63:0] out_frame_data
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WAIT = 2'b10
  } back_state_t;

  back_state_t          state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [28:0]          id_r;
  logic [63:0]          data_r;
  logic [28:0]          base_id_r;
  logic                 slot_free;
  logic                 start;
  logic                 load_direct;
  logic                 load_motion;
  lane_op_t             ops [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;
  logic [CODE_BITS-1:0] codes [NUM_LANES];

  assign slot_free   = !out_valid_r || !out_stall;
  assign start       = (state_r == B_IDLE) && job_valid && job.is_motion;
  assign load_direct = (state_r == B_IDLE) && job_valid && !job.is_motion && slot_free;
  assign load_motion = (state_r == B_WAIT) && (&lane_done) && slot_free;
  assign job_pop     = start || load_direct;

  assign ops[0] = job.trq;
  assign ops[1] = job.pos;
  assign ops[2] = job.vel;
  assign ops[3] = job.kp;
  assign ops[4] = job.kd;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mcfe_quant #(
      .CODE_BITS(CODE_BITS)
    ) u_quant (
      .clk  (clk),
      .rst_n(rst_n),
      .start(start),
      .op   (ops[g]),
      .done (lane_done[g]),
      .code (codes[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          state_nxt = B_WAIT;
        end
      end
      B_WAIT: begin
        if (load_motion) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_direct || load_motion) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_id_r <= job.frame_id;
    end
    if (load_direct) begin
      id_r   <= job.frame_id;
      data_r <= job.frame_data;
    end else if (load_motion) begin
      id_r   <= base_id_r | {5'b00000, 16'(codes[0]), 8'h00};
      data_r <= {16'(codes[1]), 16'(codes[2]), 16'(codes[3]), 16'(codes[4])};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_id   = id_r;
  assign out_frame_data = data_r;

endmodule

FILE: src/motor_can_command_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// motor_can_command_frame_encoder_unit: motor CAN command frame encoder
// Each request word on the in_ channel yields one frame word on the out_
// channel: a 29-bit extended identifier and eight data bytes. Both channels
// use valid/stall; a word moves when valid is high and stall is low.
// Enable, stop, set-zero, parameter-write and unknown kinds pass straight
// through, one word per cycle unless the output stalls or a motion word is
// in the lanes. A motion word clamps its five operands and quantizes them
// in five lanes, each a restoring divider that retires one code bit per
// cycle. The lanes take a new motion word only once the last codes are in
// the output register. A two-entry queue lets intake continue while the
// lanes are busy or the output is stalled. A stalled output word holds; the
// queue then fills and in_stall rises. Reset empties the queue, idles the
// lanes and loads the default limits. Limits are to be written on the cfg_
// port by the user while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module motor_can_command_frame_encoder_unit
  import mcfe_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [LIM_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_node_id,
  input  logic signed [31:0] in_torque,
  input  logic signed [31:0] in_position,
  input  logic signed [31:0] in_velocity,
  input  logic signed [31:0] in_stiffness_gain,
  input  logic signed [31:0] in_damping_gain,
  input  logic               in_fault_ack,
  input  logic [15:0]        in_parameter_index,
  input  logic [31:0]        in_parameter_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [28:0]        out_frame_id,
  output logic [63:0]        out_frame_data
);

  logic [LIM_W-1:0]  pos_lim_r;
  logic [LIM_W-1:0]  vel_lim_r;
  logic [LIM_W-1:0]  trq_lim_r;
  logic [LIM_W-1:0]  kp_lim_r;
  logic [LIM_W-1:0]  kd_lim_r;
  logic [HOST_W-1:0] host_r;
  logic              front_valid;
  logic              q_full;
  job_t              front_job;
  logic              q_valid;
  logic              q_pop;
  job_t              q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lim_r <= POS_LIM_RST;
      vel_lim_r <= VEL_LIM_RST;
      trq_lim_r <= TRQ_LIM_RST;
      kp_lim_r  <= KP_LIM_RST;
      kd_lim_r  <= KD_LIM_RST;
      host_r    <= HOST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_LIM: pos_lim_r <= cfg_data;
        CFG_VEL_LIM: vel_lim_r <= cfg_data;
        CFG_TRQ_LIM: trq_lim_r <= cfg_data;
        CFG_KP_LIM:  kp_lim_r  <= cfg_data;
        CFG_KD_LIM:  kd_lim_r  <= cfg_data;
        CFG_HOST:    host_r    <= cfg_data[HOST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mcfe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_node_id        (in_node_id),
    .in_torque         (in_torque),
    .in_position       (in_position),
    .in_velocity       (in_velocity),
    .in_stiffness_gain (in_stiffness_gain),
    .in_damping_gain   (in_damping_gain),
    .in_fault_ack      (in_fault_ack),
    .in_parameter_index(in_parameter_index),
    .in_parameter_bits (in_parameter_bits),
    .pos_lim           (pos_lim_r),
    .vel_lim           (vel_lim_r),
    .trq_lim           (trq_lim_r),
    .kp_lim            (kp_lim_r),
    .kd_lim            (kd_lim_r),
    .host              (host_r),
    .job_valid         (front_valid),
    .job_full          (q_full),
    .job               (front_job)
  );

  mcfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(front_valid),
    .full      (q_full),
    .push_job  (front_job),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_job   (q_job)
  );

  mcfe_back #(
    .CODE_BITS(CODE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_valid),
    .job_pop       (q_pop),
    .job           (q_job),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_id  (out_frame_id),
    .out_frame_data(out_frame_data)
  );

`ifndef NO_ASSERTIONS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_id[28:24] == 5'h00) |-> (out_frame_data == 64'h0))
    else $error("frame without type carries data");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_id[28:24] == TYPE_ZERO) |-> (out_frame_data == DATA_BYTE0_ONE))
    else $error("set-zero frame data wrong");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
